/* hw/rtl/temperature_day_statistics_defines.svh */
// Assertion macros shared by the day statistics RTL.
`ifndef TEMPERATURE_DAY_STATISTICS_DEFINES_SVH
`define TEMPERATURE_DAY_STATISTICS_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TDS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TDS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tds_pkg.sv */
// Shared constants, codes and control types of the day statistics logger.
`timescale 1ns / 1ps
`default_nettype none
package tds_pkg;

   localparam int TEMP_W     = 16;
   localparam int SLOT_W     = 3;
   localparam int CNT_W      = 11;
   localparam int FILL_W     = 4;
   localparam int TICK_W     = 8;
   localparam int MSUM_W     = 20;
   localparam int DSUM_W     = 27;
   localparam int STEP_W     = 5;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [SLOT_W-1:0] WEEK_SLOTS         = 3'd7;
   localparam logic [CNT_W-1:0]  MAX_DAY_ENTRIES    = 11'd1440;
   localparam logic [FILL_W-1:0] MAX_MINUTE_SAMPLES = 4'd10;

   localparam logic signed [TEMP_W-1:0] EMPTY_MIN = 16'sd15000;
   localparam logic signed [TEMP_W-1:0] EMPTY_MAX = -16'sd27200;

   localparam logic [TICK_W-1:0] SECONDS_RESET = 8'd60;
   localparam logic [FILL_W-1:0] SAMPLES_RESET = 4'd1;
   localparam logic [CNT_W-1:0]  ENTRIES_RESET = 11'd1440;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_CLOSE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SECONDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES = 2'd2;

   localparam logic KIND_CLOSE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef struct packed {
      logic capture;
      logic tick;
      logic div_start;
      logic log_entry;
      logic close_day;
      logic read_slot;
   } tds_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            entry_due;
      logic            slot_ok;
      logic            div_busy;
   } tds_status_type;

endpackage
`default_nettype wire

/* hw/rtl/tds_if.sv */
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
`default_nettype none
interface tds_req_if;
   import tds_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [TEMP_W-1:0] temperature;
   logic [SLOT_W-1:0]        day_slot;
   modport source (output valid, operation, temperature, day_slot, input ready);
   modport sink (input valid, operation, temperature, day_slot, output ready);
endinterface

interface tds_rsp_if;
   import tds_pkg::*;
   logic                     valid;
   logic                     ready;
   logic                     result_kind;
   logic [SLOT_W-1:0]        slot;
   logic signed [TEMP_W-1:0] day_min;
   logic signed [TEMP_W-1:0] day_max;
   logic signed [TEMP_W-1:0] day_avg;
   logic [CNT_W-1:0]         entry_count;
   logic                     day_empty;
   modport source (output valid, result_kind, slot, day_min, day_max, day_avg,
                   entry_count, day_empty, input ready);
   modport sink (input valid, result_kind, slot, day_min, day_max, day_avg,
                 entry_count, day_empty, output ready);
endinterface

interface tds_csr_if;
   import tds_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/temperature_day_statistics.sv */
// From the accepting edge: a tick without an entry ends in EXEC; a tick that makes an
// entry goes through divider load, the 27-step shared divider run and LOG; close day
// goes the same way to CLOSE, read slot to READ; both wait for a free result register.
// One beat at a time. A result waits in an output register while the next beat is taken.
// Reset (synchronous): config registers to defaults, day cleared, week ring zeroed.
// Register writes are taken every cycle.
`timescale 1ns / 1ps
`default_nettype none
module temperature_day_statistics (
   input  wire logic clock,
   input  wire logic reset,
   tds_req_if.sink   req_ch,
   tds_rsp_if.source rsp_ch,
   tds_csr_if.sink   csr_ch
);
   import tds_pkg::*;

   tds_cmd_type    cmd;
   tds_status_type status;

   assign csr_ch.ready = 1'b1;

   tds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tds_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_operation   (req_ch.operation),
      .req_temperature (req_ch.temperature),
      .req_day_slot    (req_ch.day_slot),
      .csr_write       (csr_ch.valid),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_result_kind (rsp_ch.result_kind),
      .rsp_slot        (rsp_ch.slot),
      .rsp_day_min     (rsp_ch.day_min),
      .rsp_day_max     (rsp_ch.day_max),
      .rsp_day_avg     (rsp_ch.day_avg),
      .rsp_entry_count (rsp_ch.entry_count),
      .rsp_day_empty   (rsp_ch.day_empty)
   );

endmodule
`default_nettype wire

/* hw/rtl/tds_div.sv */
// Shared signed divider, restoring, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
`default_nettype none
module tds_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [tds_pkg::DSUM_W-1:0] dividend,
   input  wire logic [tds_pkg::CNT_W-1:0]         divisor,
   output logic                                   busy,
   output logic signed [tds_pkg::TEMP_W-1:0]      quotient
);
   import tds_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [DSUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]  dsr_ff, dsr_in;

   logic [DSUM_W-1:0] mag;
   logic [CNT_W:0]    rem_sh;
   logic              fits;
   logic [TEMP_W-1:0] q_mag;

   assign mag    = dividend[DSUM_W-1] ? (~dividend + 1'b1) : dividend;
   assign rem_sh = {rem_ff, quo_ff[DSUM_W-1]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DSUM_W - 1);
         neg_in  = dividend[DSUM_W-1];
         rem_in  = '0;
         quo_in  = mag;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // shift one dividend bit in, subtract where the divisor fits
         rem_in  = fits ? CNT_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[CNT_W-1:0];
         quo_in  = {quo_ff[DSUM_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign q_mag    = quo_ff[TEMP_W-1:0];
   assign busy     = busy_ff;
   assign quotient = neg_ff ? (~q_mag + 1'b1) : q_mag;

endmodule
`default_nettype wire

/* hw/rtl/tds_ctrl.sv */
// Sequencer: accepts a beat, steps it through tick, divide, log, close or read.
`timescale 1ns / 1ps
`default_nettype none
`include "temperature_day_statistics_defines.svh"
module tds_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output tds_pkg::tds_cmd_type         cmd,
   input  wire tds_pkg::tds_status_type status
);
   import tds_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_DIV_LOAD = 3'd2;
   localparam logic [2:0] S_DIV_RUN  = 3'd3;
   localparam logic [2:0] S_LOG      = 3'd4;
   localparam logic [2:0] S_CLOSE    = 3'd5;
   localparam logic [2:0] S_READ     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.tick      = (state_ff == S_EXEC) && (status.op == OP_TICK);
      cmd.div_start = state_ff == S_DIV_LOAD;
      cmd.log_entry = state_ff == S_LOG;
      cmd.close_day = (state_ff == S_CLOSE) && out_free;
      cmd.read_slot = (state_ff == S_READ) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.op)
               OP_TICK:  state_in = status.entry_due ? S_DIV_LOAD : S_IDLE;
               OP_CLOSE: state_in = S_DIV_LOAD;
               OP_READ:  state_in = status.slot_ok ? S_READ : S_IDLE;
               default:  state_in = S_IDLE;
            endcase
         end
         S_DIV_LOAD: state_in = S_DIV_RUN;
         S_DIV_RUN: begin
            if (!status.div_busy) begin
               state_in = (status.op == OP_CLOSE) ? S_CLOSE : S_LOG;
            end
         end
         S_LOG: state_in = S_IDLE;
         S_CLOSE, S_READ: begin
            // hold until the output register is free
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.close_day || cmd.read_slot) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TDS_ASSERT_NXT(a_div_starts, cmd.div_start, status.div_busy, "divider did not start")
   `TDS_ASSERT_IMP(a_result_op, cmd.close_day || cmd.read_slot,
                   status.op == OP_CLOSE || status.op == OP_READ, "result for wrong op")

endmodule
`default_nettype wire

/* hw/rtl/tds_datapath.sv */
// Datapath: config registers, tick and minute state, day statistics, week store, output.
`timescale 1ns / 1ps
`default_nettype none
`include "temperature_day_statistics_defines.svh"
module tds_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tds_pkg::tds_cmd_type              cmd,
   output tds_pkg::tds_status_type                status,
   input  wire logic [tds_pkg::OP_W-1:0]          req_operation,
   input  wire logic signed [tds_pkg::TEMP_W-1:0] req_temperature,
   input  wire logic [tds_pkg::SLOT_W-1:0]        req_day_slot,
   input  wire logic                              csr_write,
   input  wire logic [tds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tds_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                                   rsp_result_kind,
   output logic [tds_pkg::SLOT_W-1:0]             rsp_slot,
   output logic signed [tds_pkg::TEMP_W-1:0]      rsp_day_min,
   output logic signed [tds_pkg::TEMP_W-1:0]      rsp_day_max,
   output logic signed [tds_pkg::TEMP_W-1:0]      rsp_day_avg,
   output logic [tds_pkg::CNT_W-1:0]              rsp_entry_count,
   output logic                                   rsp_day_empty
);
   import tds_pkg::*;

   // configuration
   logic [TICK_W-1:0] spl_ff;
   logic [FILL_W-1:0] spm_ff;
   logic [CNT_W-1:0]  dent_ff;

   // captured item
   logic [OP_W-1:0]          item_op_ff;
   logic signed [TEMP_W-1:0] item_temp_ff;
   logic [SLOT_W-1:0]        item_slot_ff;

   // logger state
   logic [TICK_W-1:0]        tick_count_ff;
   logic signed [MSUM_W-1:0] minute_sum_ff;
   logic [FILL_W-1:0]        minute_fill_ff;
   logic signed [TEMP_W-1:0] running_min_ff;
   logic signed [TEMP_W-1:0] running_max_ff;
   logic signed [DSUM_W-1:0] running_sum_ff;
   logic [CNT_W-1:0]         logged_count_ff;
   logic [SLOT_W-1:0]        next_slot_ff;
   logic [3*TEMP_W-1:0]      week_store_ff [WEEK_SLOTS];

   // output register
   logic                     out_kind_ff;
   logic [SLOT_W-1:0]        out_slot_ff;
   logic signed [TEMP_W-1:0] out_min_ff;
   logic signed [TEMP_W-1:0] out_max_ff;
   logic signed [TEMP_W-1:0] out_avg_ff;
   logic [CNT_W-1:0]         out_count_ff;
   logic                     out_empty_ff;

   logic [TICK_W-1:0]        tick_inc;
   logic                     sample;
   logic [FILL_W-1:0]        n_clamp;
   logic signed [MSUM_W-1:0] msum_add;
   logic [FILL_W-1:0]        fill_add;
   logic [CNT_W-1:0]         limit;
   logic signed [DSUM_W-1:0] div_dividend;
   logic [CNT_W-1:0]         div_divisor;
   logic                     div_busy;
   logic signed [TEMP_W-1:0] div_q;
   logic signed [TEMP_W-1:0] close_avg;
   logic [3*TEMP_W-1:0]      read_rec;

   assign tick_inc = tick_count_ff + 1'b1;
   assign sample   = tick_inc == spl_ff;
   assign n_clamp  = (spm_ff == '0) ? FILL_W'(1) :
                     (spm_ff > MAX_MINUTE_SAMPLES) ? MAX_MINUTE_SAMPLES : spm_ff;
   assign msum_add = minute_sum_ff + {{(MSUM_W-TEMP_W){item_temp_ff[TEMP_W-1]}}, item_temp_ff};
   assign fill_add = minute_fill_ff + 1'b1;
   assign limit    = (dent_ff > MAX_DAY_ENTRIES) ? MAX_DAY_ENTRIES : dent_ff;

   always_comb begin
      if (item_op_ff == OP_CLOSE) begin
         div_dividend = running_sum_ff;
         div_divisor  = logged_count_ff;
      end else begin
         div_dividend = {{(DSUM_W-MSUM_W){minute_sum_ff[MSUM_W-1]}}, minute_sum_ff};
         div_divisor  = {{(CNT_W-FILL_W){1'b0}}, minute_fill_ff};
      end
   end

   tds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign close_avg = (logged_count_ff == '0) ? '0 : div_q;
   assign read_rec  = week_store_ff[item_slot_ff];

   always_comb begin
      status           = '0;
      status.op        = item_op_ff;
      status.entry_due = sample && (fill_add >= n_clamp);
      status.slot_ok   = item_slot_ff < WEEK_SLOTS;
      status.div_busy  = div_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spl_ff  <= SECONDS_RESET;
         spm_ff  <= SAMPLES_RESET;
         dent_ff <= ENTRIES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SECONDS: spl_ff  <= csr_data[TICK_W-1:0];
            CSR_SAMPLES: spm_ff  <= csr_data[FILL_W-1:0];
            CSR_ENTRIES: dent_ff <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_op_ff   <= req_operation;
         item_temp_ff <= req_temperature;
         item_slot_ff <= req_day_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff   <= '0;
         minute_sum_ff   <= '0;
         minute_fill_ff  <= '0;
         running_min_ff  <= EMPTY_MIN;
         running_max_ff  <= EMPTY_MAX;
         running_sum_ff  <= '0;
         logged_count_ff <= '0;
         next_slot_ff    <= '0;
         for (int i = 0; i < WEEK_SLOTS; i++) begin
            week_store_ff[i] <= '0;
         end
      end else begin
         if (cmd.tick) begin
            tick_count_ff <= sample ? '0 : tick_inc;
            if (sample) begin
               minute_sum_ff  <= msum_add;
               minute_fill_ff <= fill_add;
            end
         end
         // minute operands go into the divider on this edge; restart the minute
         if (cmd.div_start && (item_op_ff != OP_CLOSE)) begin
            minute_sum_ff  <= '0;
            minute_fill_ff <= '0;
         end
         if (cmd.log_entry && (logged_count_ff < limit)) begin
            if (div_q < running_min_ff) begin
               running_min_ff <= div_q;
            end
            if (div_q > running_max_ff) begin
               running_max_ff <= div_q;
            end
            running_sum_ff  <= running_sum_ff + {{(DSUM_W-TEMP_W){div_q[TEMP_W-1]}}, div_q};
            logged_count_ff <= logged_count_ff + 1'b1;
         end
         if (cmd.close_day) begin
            week_store_ff[next_slot_ff] <= {running_min_ff, running_max_ff, close_avg};
            next_slot_ff    <= (next_slot_ff == WEEK_SLOTS - 1'b1) ? '0 : next_slot_ff + 1'b1;
            running_min_ff  <= EMPTY_MIN;
            running_max_ff  <= EMPTY_MAX;
            running_sum_ff  <= '0;
            logged_count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.close_day) begin
         out_kind_ff  <= KIND_CLOSE;
         out_slot_ff  <= next_slot_ff;
         out_min_ff   <= running_min_ff;
         out_max_ff   <= running_max_ff;
         out_avg_ff   <= close_avg;
         out_count_ff <= logged_count_ff;
         out_empty_ff <= logged_count_ff == '0;
      end else if (cmd.read_slot) begin
         out_kind_ff  <= KIND_READ;
         out_slot_ff  <= item_slot_ff;
         out_min_ff   <= read_rec[3*TEMP_W-1:2*TEMP_W];
         out_max_ff   <= read_rec[2*TEMP_W-1:TEMP_W];
         out_avg_ff   <= read_rec[TEMP_W-1:0];
         out_count_ff <= '0;
         out_empty_ff <= 1'b0;
      end
   end

   assign rsp_result_kind = out_kind_ff;
   assign rsp_slot        = out_slot_ff;
   assign rsp_day_min     = out_min_ff;
   assign rsp_day_max     = out_max_ff;
   assign rsp_day_avg     = out_avg_ff;
   assign rsp_entry_count = out_count_ff;
   assign rsp_day_empty   = out_empty_ff;

   `TDS_ASSERT_IMP(a_count_bound, 1'b1, logged_count_ff <= MAX_DAY_ENTRIES,
                   "day entry count past limit")
   `TDS_ASSERT_IMP(a_fill_bound, 1'b1, minute_fill_ff <= MAX_MINUTE_SAMPLES,
                   "minute fill past sample limit")
   `TDS_ASSERT_IMP(a_read_in_ring, cmd.read_slot, item_slot_ff < WEEK_SLOTS,
                   "read beyond week ring")

endmodule
`default_nettype wire
